>>> rtl/bbrc_pkg.sv
`timescale 1ns / 1ps
package bbrc_pkg;

    localparam int PIXEL_W         = 8;
    localparam int RADIUS_W        = 6;
    localparam int RING_DEPTH      = 128;
    localparam int RING_AW         = 7;
    localparam int SUM_W           = 15;
    localparam int COUNT_W         = 8;
    localparam int MAX_RADIUS_DEF  = 63;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // take the offered pixel
        logic init;      // load tap counters and clear the window sum
        logic tap;       // read one window tap from the ring
        logic div_init;  // load the divider from the finished sum
        logic div_step;  // one restoring division step
        logic emit;      // load the output register
    } t_bbrc_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit_any;   // the offered pixel releases at least one output
        logic taps_last;  // the tap being read is the last of the window
        logic div_last;   // the current division step is the last
        logic out_free;   // the output register can take a new result
        logic more;       // further flushed outputs remain in this row
    } t_bbrc_sts;

endpackage

>>> rtl/bbrc_ctrl.sv
`timescale 1ns / 1ps
module bbrc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bbrc_pkg::t_bbrc_sts i_sts,
    output bbrc_pkg::t_bbrc_cmd o_cmd
);
    import bbrc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_TAP,
        S_DRAIN,
        S_DINIT,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        o_in_ready     = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.emit_any) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_TAP;
            end
            S_TAP: begin
                o_cmd.tap = 1'b1;
                if (i_sts.taps_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.more ? S_INIT : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/bbrc_dp.sv
`timescale 1ns / 1ps
module bbrc_dp #(
    parameter int MAX_RADIUS = bbrc_pkg::MAX_RADIUS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [bbrc_pkg::RADIUS_W-1:0]     i_cfg_radius,
    input  logic [bbrc_pkg::PIXEL_W-1:0]      i_pixel,
    input  logic                              i_last_in_row,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [bbrc_pkg::PIXEL_W-1:0]      o_blurred,
    output logic                              o_row_end,
    input  bbrc_pkg::t_bbrc_cmd               i_cmd,
    output bbrc_pkg::t_bbrc_sts               o_sts
);
    import bbrc_pkg::*;

    localparam int RCAP_I = (MAX_RADIUS < 63) ? MAX_RADIUS : 63;
    localparam logic [RADIUS_W-1:0] RCAP = RADIUS_W'(RCAP_I);
    localparam logic [COUNT_W-1:0] SEEN_MAX = {COUNT_W{1'b1}};

    logic [PIXEL_W-1:0]  ring [RING_DEPTH];

    logic [RADIUS_W-1:0] r_radius;
    logic [RADIUS_W-1:0] r_row_r;
    logic [PIXEL_W-1:0]  r_first;
    logic [COUNT_W-1:0]  r_seen;
    logic [COUNT_W-1:0]  r_p;
    logic [RING_AW-1:0]  r_wr;
    logic [RADIUS_W-1:0] r_c;
    logic                r_last;
    logic signed [8:0]   r_d;
    logic [6:0]          r_left;
    logic                r_tap_v;
    logic                r_use_first;
    logic [PIXEL_W-1:0]  r_rd;
    logic [SUM_W-1:0]    r_sum;
    logic [15:0]         r_rem;
    logic [15:0]         r_dsh;
    logic [7:0]          r_q;
    logic [2:0]          r_step;
    logic                r_o_valid;
    logic [PIXEL_W-1:0]  r_o_blur;
    logic                r_o_end;

    logic [RADIUS_W-1:0] n_row_r;
    logic [RING_AW-1:0]  n_wr;
    logic [RADIUS_W-1:0] n_c;
    logic [COUNT_W-1:0]  n_seen;
    logic [7:0]          tap_dist;
    logic                use_first;
    logic [RING_AW-1:0]  rd_addr;
    logic [6:0]          win;

    // Values taken at the pixel handshake. The radius is latched per row.
    always_comb begin
        if (r_seen == '0) begin
            n_row_r = (r_radius > RCAP) ? RCAP : r_radius;
            n_wr    = r_wr;
        end else begin
            n_row_r = r_row_r;
            n_wr    = r_wr + 1'b1;
        end
        if (i_last_in_row) begin
            n_c    = (r_seen < {2'b00, n_row_r}) ? r_seen[RADIUS_W-1:0] : n_row_r;
            n_seen = '0;
        end else begin
            n_c    = n_row_r;
            n_seen = (r_seen == SEEN_MAX) ? SEEN_MAX : r_seen + 1'b1;
        end
        o_sts.emit_any = i_last_in_row || (r_seen >= {2'b00, n_row_r});
    end

    // Tap addressing: taps right of the newest pixel clamp to it, taps left
    // of the row start clamp to the first pixel.
    always_comb begin
        tap_dist  = r_d[8] ? 8'd0 : r_d[7:0];
        use_first = (tap_dist > r_p);
        rd_addr   = r_wr - tap_dist[RING_AW-1:0];
        win       = {r_row_r, 1'b1};
    end

    always_comb begin
        o_sts.taps_last = (r_left == '0);
        o_sts.div_last  = (r_step == '0);
        o_sts.out_free  = !r_o_valid || i_out_ready;
        o_sts.more      = r_last && (r_c != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            ring[n_wr] <= i_pixel;
        end
        r_rd <= ring[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= RADIUS_W'(1);
            r_row_r   <= RADIUS_W'(1);
            r_seen    <= '0;
            r_wr      <= '0;
            r_tap_v   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_radius <= i_cfg_radius;
            end
            if (i_cmd.accept) begin
                r_row_r <= n_row_r;
                r_seen  <= n_seen;
                r_wr    <= n_wr;
            end
            r_tap_v <= i_cmd.tap;
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (r_seen == '0) begin
                r_first <= i_pixel;
            end
            r_p    <= r_seen;
            r_c    <= n_c;
            r_last <= i_last_in_row;
        end
        if (i_cmd.init) begin
            r_d    <= $signed({3'b000, r_c}) + $signed({3'b000, r_row_r});
            r_left <= {r_row_r, 1'b0};
        end else if (i_cmd.tap) begin
            r_d    <= r_d - 9'sd1;
            r_left <= r_left - 1'b1;
        end
        r_use_first <= use_first;
        if (i_cmd.init) begin
            r_sum <= '0;
        end else if (r_tap_v) begin
            r_sum <= r_sum + SUM_W'(r_use_first ? r_first : r_rd);
        end
        if (i_cmd.div_init) begin
            r_rem  <= {1'b0, r_sum} + 16'(r_row_r);
            r_dsh  <= {2'b00, win, 7'b0};
            r_q    <= '0;
            r_step <= 3'd7;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[6:0], 1'b1};
            end else begin
                r_q   <= {r_q[6:0], 1'b0};
            end
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - 1'b1;
        end
        if (i_cmd.emit) begin
            r_o_blur <= r_q;
            r_o_end  <= r_last && (r_c == '0);
            if (r_c != '0) begin
                r_c <= r_c - 1'b1;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_blurred   = r_o_blur;
    assign o_row_end   = r_o_end;

endmodule

>>> rtl/box_blur_row_clamped.sv
`timescale 1ns / 1ps
// Horizontal box blur of a streamed pixel row with edge replication.
// Pixels enter on the input channel (i_in_valid / o_in_ready) left to right;
// i_last_in_row marks the final pixel of a row. Each output request on
// (o_out_valid / i_out_ready) carries the rounded window average of one
// position; o_row_end marks the final output of a row.
// The radius is written through its own channel (i_cfg_valid / o_cfg_ready),
// which is always ready; a new radius takes effect at the next row start and
// is saturated to MAX_RADIUS.
// A pixel that releases no output is taken without leaving the idle state.
// Output x leaves once pixel x+r is in; the last pixel flushes all pending
// outputs. Each output passes through setup, one ring read per window tap,
// a read drain, the divider load, eight steps of the restoring divider,
// and the load of the output register.
// New pixels are taken only between rows of work, once the results of the
// previous pixel are all computed.
// Reset (synchronous, active low) empties the pipeline, starts a new row and
// sets the radius to 1. A stalled receiver holds the result in the output
// register; computation of the next result goes on and waits only at load.
module box_blur_row_clamped #(
    parameter int MAX_RADIUS = bbrc_pkg::MAX_RADIUS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bbrc_pkg::RADIUS_W-1:0] i_cfg_radius,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bbrc_pkg::PIXEL_W-1:0]  i_pixel,
    input  logic                          i_last_in_row,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bbrc_pkg::PIXEL_W-1:0]  o_blurred,
    output logic                          o_row_end
);
    import bbrc_pkg::*;

    t_bbrc_cmd cmd;
    t_bbrc_sts sts;

    // The radius register is written in any cycle.
    assign o_cfg_ready = 1'b1;

    // The controller sequences taps, division and output loading.
    bbrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the pixel ring, the window sum and the divider.
    bbrc_dp #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_radius  (i_cfg_radius),
        .i_pixel       (i_pixel),
        .i_last_in_row (i_last_in_row),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_blurred     (o_blurred),
        .o_row_end     (o_row_end),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule
